/* sv/base64_stream_encoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Base64 stream encoder.
// Each macro checks one property on the rising edge of clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64e: next-cycle check failed");

`endif

/* sv/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int ROOM_W = 16;
    localparam logic [ROOM_W-1:0] ROOM_RESET = 16'hFFFF;
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [1:0] LAST_SLOT = 2'd3;

    // One unit of work for the back end: a padded or full group, or a bare
    // done marker when nothing is emitted.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pads;
        logic        marker;
        logic        done;
        logic        ovf;
    } b64e_job_t;

    typedef struct packed {
        logic      push;
        b64e_job_t job;
    } b64e_push_t;

    typedef struct packed {
        logic      valid;
        b64e_job_t job;
    } b64e_head_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64e_alpha(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26)
            return v8 + 8'd65;
        else if (v < 6'd52)
            return v8 + 8'd71;
        else if (v < 6'd62)
            return v8 - 8'd4;
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

/* sv/b64e_in_if.sv */
// ----------------------------------------------------------------------------
// b64e_in_if
// Input channel: one beat is a data byte or an end-of-message command.
// ----------------------------------------------------------------------------
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

/* sv/b64e_out_if.sv */
// ----------------------------------------------------------------------------
// b64e_out_if
// Output channel: one beat is one character or a done marker.
// ----------------------------------------------------------------------------
interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       message_done;
    logic       overflow;
    logic       last_in_run;

    modport source (output valid, output out_char, output char_valid,
                    output message_done, output overflow, output last_in_run,
                    input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input message_done, input overflow, input last_in_run,
                    output ready);
endinterface

/* sv/base64_stream_encoder.sv */
// An accepted item is written into the job queue, loaded into the back end's current job and
// then spelled out through the output register onto char_chan. The block takes one input beat
// per cycle while the two-entry job queue has room; each emitted group is spelled out as four
// character beats. A done marker with nothing to flush takes a single output beat.
// Reset (rst_n low, asynchronous) empties the queue and the output stage, clears the held
// group, character count and overflow flag, and sets room_reg to 65535.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder (standard alphabet) with a per-message output budget.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ROOM_W-1:0] cfg_wdata,
    b64e_in_if.sink           data_chan,
    b64e_out_if.source        char_chan
);

    // The front end owns the message state: the held bytes, the running
    // character count and the overflow flag. It decides at acceptance
    // whether a group is emitted, dropped, or turned into a done marker,
    // so the budget check never waits on the output side.
    b64e_push_t q_push;
    logic       q_full;

    // The queue lets the front keep taking beats while the back end is
    // still spelling out an earlier group.
    b64e_head_t q_head;
    logic       pop;

    b64e_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .data_chan (data_chan),
        .q_full    (q_full),
        .q_push    (q_push)
    );

    b64e_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_full (q_full),
        .q_head (q_head)
    );

    // The back end turns each job into beats, one per cycle while the consumer keeps up. Its output
    // register decouples it from a stalled consumer: it refills as soon as
    // the current beat is taken.
    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .pop       (pop),
        .char_chan (char_chan)
    );

endmodule

/* sv/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Collects bytes into groups, checks the output budget and issues jobs.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ROOM_W-1:0] cfg_wdata,
    b64e_in_if.sink           data_chan,
    input  logic              q_full,
    output b64e_push_t        q_push
);

    localparam int SUM_W = ((COUNT_BITS > ROOM_W) ? COUNT_BITS : ROOM_W) + 1;

    logic [ROOM_W-1:0]     room_reg;
    logic [15:0]           held_reg, held_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] cw_reg, cw_next;
    logic                  ovf_reg, ovf_next;

    logic             accept;
    logic             fits;
    logic [SUM_W-1:0] sum;

    assign data_chan.ready = !q_full;
    assign accept = data_chan.valid && !q_full;

    assign sum  = SUM_W'(cw_reg) + SUM_W'(3'd4);
    assign fits = sum <= SUM_W'(room_reg);

    always_comb
    begin
        held_next   = held_reg;
        cnt_next    = cnt_reg;
        cw_next     = cw_reg;
        ovf_next    = ovf_reg;
        q_push      = '0;
        if (accept)
        begin
            if (!data_chan.op)
            begin
                if (cnt_reg == 2'd2)
                begin
                    held_next = '0;
                    cnt_next  = '0;
                    if (!ovf_reg)
                    begin
                        if (fits)
                        begin
                            q_push.push     = 1'b1;
                            q_push.job.bits = {held_reg, data_chan.data_byte};
                            cw_next         = cw_reg + COUNT_BITS'(3'd4);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    held_next = {held_reg[7:0], data_chan.data_byte};
                    cnt_next  = cnt_reg + 2'd1;
                end
            end
            else
            begin
                // End of message: flush a partial group if it fits, else a marker.
                q_push.push     = 1'b1;
                q_push.job.done = 1'b1;
                if (cnt_reg != 2'd0 && !ovf_reg && fits)
                begin
                    if (cnt_reg == 2'd1)
                    begin
                        q_push.job.bits = {held_reg[7:0], 16'h0000};
                        q_push.job.pads = 2'd2;
                    end
                    else
                    begin
                        q_push.job.bits = {held_reg, 8'h00};
                        q_push.job.pads = 2'd1;
                    end
                end
                else
                begin
                    q_push.job.marker = 1'b1;
                    q_push.job.ovf    = ovf_reg || (cnt_reg != 2'd0);
                end
                held_next = '0;
                cnt_next  = '0;
                cw_next   = '0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg <= ROOM_RESET;
            held_reg <= '0;
            cnt_reg  <= '0;
            cw_reg   <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                room_reg <= cfg_wdata;
            end
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
            cw_reg   <= cw_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

/* sv/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  b64e_push_t q_push,
    input  logic       pop,
    output logic       q_full,
    output b64e_head_t q_head
);

    b64e_job_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign q_full       = cnt_reg == 2'd2;
    assign q_head.valid = cnt_reg != 2'd0;
    assign q_head.job   = slot_reg[rd_ptr_reg];
    assign do_pop       = pop && q_head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ q_push.push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, q_push.push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            slot_reg[wr_ptr_reg] <= q_push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Expands each job into character beats, one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  b64e_head_t q_head,
    output logic       pop,
    b64e_out_if.source char_chan
);

    b64e_job_t  cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg, char_next;
    logic       cv_reg, cv_next;
    logic       done_reg, done_next;
    logic       ovf_reg, ovf_next;
    logic       last_reg, last_next;

    logic       last_beat;
    logic       advance;
    logic [5:0] six;
    logic       is_pad;

    assign last_beat = cur_reg.marker || idx_reg == LAST_SLOT;
    assign advance   = cur_valid_reg && (!out_valid_reg || char_chan.ready);
    assign pop       = q_head.valid && (!cur_valid_reg || (advance && last_beat));

    always_comb
    begin
        unique case (idx_reg)
            2'd0: six = cur_reg.bits[23:18];
            2'd1: six = cur_reg.bits[17:12];
            2'd2: six = cur_reg.bits[11:6];
            2'd3: six = cur_reg.bits[5:0];
            default: six = '0;
        endcase
        // Trailing slots covered by padding show '='.
        is_pad = ({1'b0, idx_reg} + {1'b0, cur_reg.pads}) >= 3'd4;
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_next       = q_head.job;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (advance)
        begin
            cur_valid_next = !last_beat;
            idx_next       = idx_reg + 2'd1;
        end

        out_valid_next = out_valid_reg && !char_chan.ready;
        char_next      = char_reg;
        cv_next        = cv_reg;
        done_next      = done_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            ovf_next       = cur_reg.ovf;
            last_next      = last_beat;
            done_next      = cur_reg.done && last_beat;
            cv_next        = !cur_reg.marker;
            if (cur_reg.marker)
                char_next = 8'h00;
            else if (is_pad)
                char_next = PAD_CHAR;
            else
                char_next = b64e_alpha(six);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        char_reg <= char_next;
        cv_reg   <= cv_next;
        done_reg <= done_next;
        ovf_reg  <= ovf_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign char_chan.valid        = out_valid_reg;
    assign char_chan.out_char     = char_reg;
    assign char_chan.char_valid   = cv_reg;
    assign char_chan.message_done = done_reg;
    assign char_chan.overflow     = ovf_reg;
    assign char_chan.last_in_run  = last_reg;

    // A done marker is a lone zero beat that closes its run.
    `B64E_ASSERT_IMP(a_marker_form, out_valid_reg && !cv_reg, done_reg && last_reg && char_reg == 8'h00)
    // Message completion always ends the run of its item.
    `B64E_ASSERT_IMP(a_done_is_last, out_valid_reg && done_reg, last_reg)
    // Characters are only sent while the message is within budget.
    `B64E_ASSERT_IMP(a_char_no_ovf, out_valid_reg && cv_reg, !ovf_reg)
    // A group in progress is never dropped before its fourth character.
    `B64E_ASSERT_NEXT(a_group_kept, cur_valid_reg && !last_beat, cur_valid_reg)

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for base64_stream_encoder
// Drives data bytes and end-of-message commands under random flow control.
// A built-in Base64 predictor computes the expected output beats, and each
// beat that the block delivers is checked against the oldest expected beat.
// ----------------------------------------------------------------------------
module tb;
    import b64e_pkg::*;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Settle time before a room write, longer than the path through the queue and output register plus
    // the drain of a dropped group that never shows up at the output.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One beat of the input channel.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } in_beat_t;

    // One beat of the output channel, in the order the fields are compared.
    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       done;
        logic       ovf;
        logic       last;
    } char_beat_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [ROOM_W-1:0] cfg_wdata;

    b64e_in_if  in_chan();
    b64e_out_if out_chan();

    base64_stream_encoder #(
        .COUNT_BITS (16)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .data_chan (in_chan),
        .char_chan (out_chan)
    );

    // Beats waiting to be offered, and output beats still owed by the block.
    in_beat_t   pending_beats[$];
    char_beat_t char_expect[$];

    int beats_queued   = 0;
    int beats_accepted = 0;
    int mismatches     = 0;

    // Flow control knobs. The main sequence clears idling near the end and
    // arms the long receiver hold-off during the first random phase.
    bit calm      = 1'b0;
    bit hold_arm  = 1'b0;
    int hold_from = 0;
    bit sink_hold;
    int src_gap   = 0;
    int sink_gap  = 0;

    // Predictor state: the room register and the per-message encoder state.
    logic [ROOM_W-1:0] room_limit   = ROOM_RESET;
    logic [15:0]       held_pair    = '0;
    logic [1:0]        held_count   = '0;
    logic [15:0]       chars_sent   = '0;
    logic              overflow_seen = 1'b0;

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Turns a 24-bit group into four characters if it fits in the remaining
    // room. A group that does not fit is dropped whole and latches overflow;
    // once overflow is latched every later group of the message is dropped.
    function automatic bit emit_group(input logic [23:0] bits, input int pads,
                                      input logic done);
        char_beat_t b;
        if (overflow_seen)
            return 1'b0;
        if ({1'b0, chars_sent} + 17'd4 > {1'b0, room_limit})
        begin
            overflow_seen = 1'b1;
            return 1'b0;
        end
        for (int i = 0; i < 4; i++)
        begin
            b.ch   = (i >= 4 - pads) ? PAD_CHAR : ALPHABET[bits[18 - 6 * i +: 6]];
            b.cv   = 1'b1;
            b.done = (i == 3) ? done : 1'b0;
            b.ovf  = overflow_seen;
            b.last = (i == 3);
            char_expect.push_back(b);
        end
        chars_sent = chars_sent + 16'd4;
        return 1'b1;
    endfunction

    // Works out the output beats caused by one accepted input beat.
    function automatic void encode_beat(input logic op, input logic [7:0] data_in);
        bit         emitted;
        char_beat_t b;
        emitted = 1'b0;
        if (op == OP_DATA)
        begin
            // The third byte completes a group; the first two are only held.
            if (held_count == 2'd2)
            begin
                held_count = '0;
                void'(emit_group({held_pair, data_in}, 0, 1'b0));
                held_pair = '0;
            end
            else
            begin
                held_pair  = {held_pair[7:0], data_in};
                held_count = held_count + 2'd1;
            end
        end
        else
        begin
            // End of message: flush one or two held bytes as a padded group.
            if (held_count == 2'd1)
                emitted = emit_group({held_pair[7:0], 16'h0000}, 2, 1'b1);
            else if (held_count == 2'd2)
                emitted = emit_group({held_pair, 8'h00}, 1, 1'b1);
            // Nothing flushed: a bare done marker carries the overflow status.
            if (!emitted)
            begin
                b.ch   = 8'h00;
                b.cv   = 1'b0;
                b.done = 1'b1;
                b.ovf  = overflow_seen;
                b.last = 1'b1;
                char_expect.push_back(b);
            end
            held_pair     = '0;
            held_count    = '0;
            chars_sent    = '0;
            overflow_seen = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued beats, with random bursts of idle cycles.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chan.valid     <= 1'b0;
            in_chan.op        <= OP_DATA;
            in_chan.data_byte <= 8'h00;
        end
        else
        begin
            // The beat on the bus was taken at this edge: predict its results.
            if (in_chan.valid && in_chan.ready)
            begin
                encode_beat(in_chan.op, in_chan.data_byte);
                beats_accepted++;
            end
            // The bus is free for a new beat unless one is still being held.
            if (!in_chan.valid || in_chan.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_chan.valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    in_beat_t nb;
                    nb = pending_beats.pop_front();
                    in_chan.valid     <= 1'b1;
                    in_chan.op        <= nb.op;
                    in_chan.data_byte <= nb.data;
                    if (!calm && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 5);
                end
                else
                begin
                    in_chan.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each delivered beat and drives ready, with random stall
    // bursts and the long hold-off that backs the block up into its input.
    // ------------------------------------------------------------------------
    function automatic void flag_mismatch(input string what, input char_beat_t want,
                                          input char_beat_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected char=%h cv=%b done=%b ovf=%b last=%b, ",
                     $realtime, what, want.ch, want.cv, want.done, want.ovf, want.last,
                     "got char=%h cv=%b done=%b ovf=%b last=%b",
                     got.ch, got.cv, got.done, got.ovf, got.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_chan.ready <= 1'b0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                char_beat_t got;
                char_beat_t want;
                got = {out_chan.out_char, out_chan.char_valid, out_chan.message_done,
                       out_chan.overflow, out_chan.last_in_run};
                if (char_expect.size() == 0)
                begin
                    want = '0;
                    flag_mismatch("beat with nothing expected", want, got);
                end
                else
                begin
                    want = char_expect.pop_front();
                    if (got.ch !== want.ch || got.cv !== want.cv || got.done !== want.done
                        || got.ovf !== want.ovf || got.last !== want.last)
                        flag_mismatch("beat mismatch", want, got);
                end
            end
            if (sink_hold)
            begin
                out_chan.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_chan.ready <= 1'b0;
            end
            else
            begin
                out_chan.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 5);
            end
        end
    end

    // Long receiver hold-off, counted here in cycles. It starts a few beats
    // into the first random phase, while the sender still has plenty to offer.
    initial
    begin
        sink_hold = 1'b0;
        wait (hold_arm);
        wait (beats_accepted >= hold_from);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_beat(input logic op, input logic [7:0] data);
        in_beat_t nb;
        nb.op   = op;
        nb.data = data;
        pending_beats.push_back(nb);
        beats_queued++;
    endtask

    // A message of random bytes, closed by an end-of-message command.
    task automatic queue_message(input int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            queue_beat(OP_DATA, 8'($urandom_range(0, 255)));
        queue_beat(OP_END, 8'($urandom_range(0, 255)));
    endtask

    // Whole messages until about n_beats beats are queued. Mostly short
    // messages; now and then a long one to run past a small room.
    task automatic queue_random_phase(input int n_beats);
        int goal;
        goal = beats_queued + n_beats;
        while (beats_queued < goal)
        begin
            if ($urandom_range(0, 5) == 0)
                queue_message($urandom_range(10, 16));
            else
                queue_message($urandom_range(0, 9));
        end
    endtask

    // Waits until every queued beat was taken and every result arrived, then
    // lets the block settle so that a dropped group is fully done.
    task automatic wait_idle();
        wait (beats_accepted == beats_queued && char_expect.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Room writes happen only while the block is idle.
    task automatic set_room(input logic [ROOM_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        room_limit = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_chan.valid     = 1'b0;
        in_chan.op        = OP_DATA;
        in_chan.data_byte = 8'h00;
        out_chan.ready    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Full room. An all-zero group, a group that uses both '+' and '/',
        // a one-byte flush with two pads, a two-byte flush with one pad, and
        // end of message with nothing held.
        set_room(16'hFFFF);
        queue_beat(OP_DATA, 8'h00);
        queue_beat(OP_DATA, 8'h00);
        queue_beat(OP_DATA, 8'h00);
        queue_beat(OP_END,  8'hFF);
        queue_beat(OP_DATA, 8'hFB);
        queue_beat(OP_DATA, 8'hFF);
        queue_beat(OP_DATA, 8'hBF);
        queue_beat(OP_DATA, 8'hFF);
        queue_beat(OP_END,  8'h00);
        queue_beat(OP_DATA, 8'h4D);
        queue_beat(OP_DATA, 8'h61);
        queue_beat(OP_END,  8'h00);
        queue_beat(OP_END,  8'h5A);

        // No room at all: a padded flush and a full group are both dropped,
        // and each done marker reports the overflow.
        set_room(16'h0000);
        queue_beat(OP_DATA, 8'h41);
        queue_beat(OP_END,  8'h00);
        queue_beat(OP_DATA, 8'h12);
        queue_beat(OP_DATA, 8'h34);
        queue_beat(OP_DATA, 8'h56);
        queue_beat(OP_END,  8'h00);

        // Room for exactly one group: the first group fits, the padded
        // flush does not.
        set_room(16'd4);
        queue_beat(OP_DATA, 8'h01);
        queue_beat(OP_DATA, 8'h02);
        queue_beat(OP_DATA, 8'h03);
        queue_beat(OP_DATA, 8'h04);
        queue_beat(OP_DATA, 8'h05);
        queue_beat(OP_END,  8'h00);

        // Random phases. The first one runs with full room and carries the
        // long receiver hold-off.
        set_room(16'hFFFF);
        hold_from = beats_accepted + 4;
        queue_random_phase(30);
        hold_arm = 1'b1;

        set_room(16'd8);
        queue_random_phase(15);

        set_room(16'($urandom_range(0, 40)));
        queue_random_phase(15);

        set_room(16'd12);
        queue_random_phase(15);

        // Last part runs without any idling on either side.
        set_room(16'd20);
        calm = 1'b1;
        queue_random_phase(15);

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && char_expect.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
